@@ rtl/sbl_pkg.sv @@
package sbl_pkg;

   // Number of direction words, one per bit of the Gray-code index.
   localparam int unsigned TABLE_DEPTH = 32;
   // Width of a full direction word and of the external point and result fields.
   localparam int unsigned FULL_BITS = 32;
   localparam int unsigned STEP_BITS = 6;

   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned CSR_DATA_BITS  = 64;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_DIMENSION    = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEGREE             = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLY_COEFFICIENTS  = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_DIRECTIONS = 8'd3;

   // Reset values of the configuration registers.
   localparam logic        FIRST_DIMENSION_RESET    = 1'b1;
   localparam logic [3:0]  DEGREE_RESET             = 4'd1;
   localparam logic [6:0]  POLY_COEFFICIENTS_RESET  = 7'd0;
   localparam logic [63:0] INITIAL_DIRECTIONS_RESET = 64'h0101_0101_0101_0101;

   // Control that travels with one index down the chain of cells.
   typedef struct packed {
      logic                 valid;
      logic [FULL_BITS-1:0] gray;
   } stage_ctl_type;

endpackage

@@ rtl/sbl_req_if.sv @@
interface sbl_req_if;
   logic                          valid;
   logic                          ready;
   logic [sbl_pkg::FULL_BITS-1:0] point_count;

   modport source (output valid, output point_count, input ready);
   modport sink (input valid, input point_count, output ready);
endinterface

@@ rtl/sbl_rsp_if.sv @@
interface sbl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbl_pkg::FULL_BITS-1:0] coordinate;

   modport source (output valid, output coordinate, input ready);
   modport sink (input valid, input coordinate, output ready);
endinterface

@@ rtl/sbl_csr_if.sv @@
interface sbl_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sbl_pkg::CSR_INDEX_BITS-1:0] index;
   logic [sbl_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sobol_point_generator_unit.sv @@
// Channel  Direction  Payload                      Word accepted when
// req_if   in         point_count[31:0]            req_if.valid && req_if.ready
// rsp_if   out        coordinate[31:0]             rsp_if.valid && rsp_if.ready
// csr_if   in         index[7:0], data[63:0]       csr_if.valid && csr_if.ready
//
// One request word enters per cycle while the chain advances and no rebuild
// runs; its coordinate then passes one cell of the chain per Gray-code bit.
// After reset and after each write to one of the four configuration registers
// the direction table is rebuilt, one word pushed into the chain per cycle,
// and req_if.ready is low for that time. csr_if.ready is always high.
// A stall on rsp_if freezes the whole chain, and req_if.ready follows it.
module sobol_point_generator_unit #(
   parameter int unsigned MAX_DEGREE    = 8,
   parameter int unsigned FRACTION_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   sbl_req_if.sink      req_if,
   sbl_rsp_if.source    rsp_if,
   sbl_csr_if.sink      csr_if
);

   localparam int unsigned DEPTH = sbl_pkg::TABLE_DEPTH;

   // The chain: link b handles bit b of the Gray-code index and holds
   // direction word b+1. Entry 0 of ctl and acc is the chain's input.
   sbl_pkg::stage_ctl_type     ctl  [0:DEPTH];
   logic [FRACTION_BITS-1:0]   acc  [0:DEPTH];
   logic [FRACTION_BITS-1:0]   dir  [0:DEPTH-1];
   logic [FRACTION_BITS-1:0]   window [0:MAX_DEGREE-1];
   logic [FRACTION_BITS-1:0]   new_word;
   logic [sbl_pkg::FULL_BITS-1:0] index_m1;
   logic                       busy;
   logic                       advance;

   // The chain moves whenever the output link is empty or being drained.
   assign advance      = !ctl[DEPTH].valid || rsp_if.ready;
   assign req_if.ready = advance && !busy;
   assign csr_if.ready = 1'b1;

   // Point N asks for index N-1 in Gray-code order; N of zero wraps.
   assign index_m1     = req_if.point_count - sbl_pkg::FULL_BITS'(1);
   assign ctl[0].valid = req_if.valid && req_if.ready;
   assign ctl[0].gray  = index_m1 ^ (index_m1 >> 1);
   assign acc[0]       = '0;

   // During a rebuild each word steps one link down the chain, so the most
   // recent words sit at the top end, where the builder reads them.
   for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_window
      assign window[k] = dir[DEPTH-1-k];
   end

   sbl_dir_builder #(
      .MAX_DEGREE    (MAX_DEGREE),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_builder (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .window   (window),
      .busy     (busy),
      .new_word (new_word)
   );

   for (genvar b = 0; b < DEPTH; b++) begin : g_cell
      logic [FRACTION_BITS-1:0] word_in;

      if (b == DEPTH - 1) begin : g_top
         assign word_in = new_word;
      end else begin : g_mid
         assign word_in = dir[b+1];
      end

      sbl_cell #(
         .WIDTH   (FRACTION_BITS),
         .BIT_POS (b)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .shift_en (busy),
         .word_in  (word_in),
         .word_out (dir[b]),
         .ctl_in   (ctl[b]),
         .acc_in   (acc[b]),
         .ctl_out  (ctl[b+1]),
         .acc_out  (acc[b+1])
      );
   end

   // Only the upper bits of each word are kept, so the coordinate is already
   // scaled by 2^FRACTION_BITS and needs only zero extension.
   assign rsp_if.valid      = ctl[DEPTH].valid;
   assign rsp_if.coordinate = sbl_pkg::FULL_BITS'(acc[DEPTH]);

`ifndef ASSERT_OFF
   a_no_accept_in_rebuild: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_if.ready)
      else $error("request accepted during table rebuild");

   a_first_link_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && ctl[1].valid) |=> ctl[2].valid)
      else $error("word lost between first links of the chain");

   a_stall_freezes_output: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (ctl[DEPTH].valid && $stable(acc[DEPTH])))
      else $error("output link changed during a stall");

   a_rebuild_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (!busy && !csr_if.valid) |=> !busy)
      else $error("table rebuild started without a configuration write");
`endif

endmodule

@@ rtl/sbl_cell.sv @@
// One link of the chain: holds one direction word and folds it into the
// running XOR of any index that passes through with this link's bit set.
module sbl_cell #(
   parameter int unsigned WIDTH   = 32,
   parameter int unsigned BIT_POS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   shift_en,
   input  logic [WIDTH-1:0]       word_in,
   output logic [WIDTH-1:0]       word_out,
   input  sbl_pkg::stage_ctl_type ctl_in,
   input  logic [WIDTH-1:0]       acc_in,
   output sbl_pkg::stage_ctl_type ctl_out,
   output logic [WIDTH-1:0]       acc_out
);

   sbl_pkg::stage_ctl_type ctl_ff;
   logic [WIDTH-1:0]       acc_ff;
   logic [WIDTH-1:0]       dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= ctl_in.gray[BIT_POS] ? (acc_in ^ dir_ff) : acc_in;
      end
      if (shift_en) begin
         dir_ff <= word_in;
      end
   end

   assign word_out = dir_ff;
   assign ctl_out  = ctl_ff;
   assign acc_out  = acc_ff;

endmodule

@@ rtl/sbl_dir_builder.sv @@
// Holds the configuration registers and produces one direction word per
// cycle while the table is rebuilt; the words are pushed into the top end
// of the cell chain.
module sbl_dir_builder #(
   parameter int unsigned MAX_DEGREE    = 8,
   parameter int unsigned FRACTION_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [sbl_pkg::CSR_INDEX_BITS-1:0] wr_index,
   input  logic [sbl_pkg::CSR_DATA_BITS-1:0]  wr_data,
   input  logic [FRACTION_BITS-1:0]           window [0:MAX_DEGREE-1],
   output logic                               busy,
   output logic [FRACTION_BITS-1:0]           new_word
);

   logic                              first_dim_ff;
   logic [3:0]                        degree_ff;
   logic [6:0]                        poly_ff;
   logic [63:0]                       init_ff;
   logic                              busy_ff;
   logic [sbl_pkg::STEP_BITS-1:0]     step_ff;

   logic                              restart;
   logic [3:0]                        s_eff;
   logic [sbl_pkg::STEP_BITS-1:0]     shamt;
   logic [2:0]                        bsel;
   logic [7:0]                        m_byte;
   logic [sbl_pkg::FULL_BITS-1:0]     full_word;
   logic [FRACTION_BITS-1:0]          base;
   logic [FRACTION_BITS-1:0]          rec_word;
   logic [3:0]                        pidx;

   always_comb begin
      unique case (wr_index)
         sbl_pkg::CSR_FIRST_DIMENSION,
         sbl_pkg::CSR_DEGREE,
         sbl_pkg::CSR_POLY_COEFFICIENTS,
         sbl_pkg::CSR_INITIAL_DIRECTIONS: restart = wr_en;
         default:                         restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_dim_ff <= sbl_pkg::FIRST_DIMENSION_RESET;
         degree_ff    <= sbl_pkg::DEGREE_RESET;
         poly_ff      <= sbl_pkg::POLY_COEFFICIENTS_RESET;
         init_ff      <= sbl_pkg::INITIAL_DIRECTIONS_RESET;
         busy_ff      <= 1'b1;
         step_ff      <= sbl_pkg::STEP_BITS'(1);
      end else if (restart) begin
         unique case (wr_index)
            sbl_pkg::CSR_FIRST_DIMENSION:   first_dim_ff <= wr_data[0];
            sbl_pkg::CSR_DEGREE:            degree_ff    <= wr_data[3:0];
            sbl_pkg::CSR_POLY_COEFFICIENTS: poly_ff      <= wr_data[6:0];
            default:                        init_ff      <= wr_data;
         endcase
         busy_ff <= 1'b1;
         step_ff <= sbl_pkg::STEP_BITS'(1);
      end else if (busy_ff) begin
         if (step_ff == sbl_pkg::STEP_BITS'(sbl_pkg::TABLE_DEPTH)) begin
            busy_ff <= 1'b0;
         end
         step_ff <= step_ff + sbl_pkg::STEP_BITS'(1);
      end
   end

   // Effective degree: zero counts as one, large values saturate.
   always_comb begin
      if (degree_ff == 4'd0) begin
         s_eff = 4'd1;
      end else if (degree_ff > 4'(MAX_DEGREE)) begin
         s_eff = 4'(MAX_DEGREE);
      end else begin
         s_eff = degree_ff;
      end
   end

   // Words 1..s come straight from configuration, placed at bit 32-k.
   assign shamt  = sbl_pkg::STEP_BITS'(sbl_pkg::TABLE_DEPTH) - step_ff;
   assign bsel   = 3'(step_ff - sbl_pkg::STEP_BITS'(1));
   assign m_byte = init_ff[{bsel, 3'b000} +: 8];

   always_comb begin
      if (first_dim_ff) begin
         full_word = sbl_pkg::FULL_BITS'(1) << shamt;
      end else begin
         full_word = {24'd0, m_byte} << shamt;
      end
   end

   // Recurrence; window[k-1] holds the k-th most recently pushed word.
   always_comb begin
      base = '0;
      for (int j = 0; j < MAX_DEGREE; j++) begin
         if (4'(j + 1) == s_eff) begin
            base = window[j];
         end
      end
      rec_word = base ^ (base >> s_eff);
      for (int k = 1; k < MAX_DEGREE; k++) begin
         pidx = s_eff - 4'(k) - 4'd1;
         if ((4'(k) < s_eff) && poly_ff[pidx[2:0]]) begin
            rec_word = rec_word ^ window[k-1];
         end
      end
   end

   always_comb begin
      if (first_dim_ff || (step_ff <= {2'b00, s_eff})) begin
         new_word = full_word[sbl_pkg::FULL_BITS-1 -: FRACTION_BITS];
      end else begin
         new_word = rec_word;
      end
   end

   assign busy = busy_ff;

endmodule

@@ dv/sobol_point_generator_unit_tb.sv @@
`timescale 1ns / 1ps

module sobol_point_generator_unit_tb;
   import sbl_pkg::*;

   localparam int unsigned MAX_DEGREE    = 8;
   localparam int unsigned FRACTION_BITS = 32;

   // Clock period is 20 ns.  The limit below leaves a very wide margin over
   // the slowest legal run.
   localparam int unsigned RUN_LIMIT_NS      = 5_000_000;
   localparam int unsigned RESET_CYCLES      = 6;
   localparam int unsigned HOLD_OFF_CYCLES   = 400;
   localparam int unsigned POINTS_PER_SETUP  = 135;
   localparam int unsigned DRAIN_CYCLES      = 40;

   // Indexes past the end of the register list.  Writes to them must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 8'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_INDEX    = 8'hFF;

   // The scoreboard keeps its own copy of the registers and of the direction
   // table.  It predicts each coordinate when its point count is accepted,
   // because only the bench holds register writes back until the block is idle.
   class coordinate_scoreboard;
      bit          first_dimension;
      bit [3:0]    degree;
      bit [6:0]    poly_coefficients;
      bit [63:0]   initial_directions;
      bit [31:0]   direction_word [1:32];
      bit [31:0]   expected_coordinates [$];
      int unsigned mismatches;
      int unsigned points_noted;
      int unsigned coordinates_checked;

      function new();
         first_dimension    = FIRST_DIMENSION_RESET;
         degree             = DEGREE_RESET;
         poly_coefficients  = POLY_COEFFICIENTS_RESET;
         initial_directions = INITIAL_DIRECTIONS_RESET;
         mismatches          = 0;
         points_noted        = 0;
         coordinates_checked = 0;
         rebuild_directions();
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_FIRST_DIMENSION:    first_dimension    = data[0];
            CSR_DEGREE:             degree             = data[3:0];
            CSR_POLY_COEFFICIENTS:  poly_coefficients  = data[6:0];
            CSR_INITIAL_DIRECTIONS: initial_directions = data;
            default:                return;
         endcase
         rebuild_directions();
      endfunction

      // Standard Sobol recurrence.  A degree of zero acts as one and a degree
      // above the maximum saturates; coefficient bits above s-2 never matter.
      function void rebuild_directions();
         int unsigned s;
         int unsigned i;
         int unsigned k;
         logic [63:0] seed;
         logic [31:0] v;
         s = degree;
         if (s < 1) s = 1;
         if (s > MAX_DEGREE) s = MAX_DEGREE;
         if (first_dimension) begin
            for (i = 1; i <= 32; i++) direction_word[i] = 32'h1 << (32 - i);
            return;
         end
         for (i = 1; i <= s; i++) begin
            // Only the low 32 bits of the shifted start value survive.
            seed = {56'd0, initial_directions[8*(i-1) +: 8]} << (32 - i);
            direction_word[i] = seed[31:0];
         end
         for (i = s + 1; i <= 32; i++) begin
            v = direction_word[i-s];
            v ^= v >> s;
            for (k = 1; k < s; k++)
               if (poly_coefficients[s-1-k]) v ^= direction_word[i-k];
            direction_word[i] = v;
         end
      endfunction

      // Point N sits at Gray-code index N-1; a count of zero wraps to the top.
      function bit [31:0] coordinate_of(bit [31:0] point_count);
         bit [31:0] index;
         bit [31:0] gray;
         bit [31:0] x;
         index = point_count - 32'd1;
         gray  = index ^ (index >> 1);
         x     = '0;
         for (int b = 0; b < 32; b++)
            if (gray[b]) x ^= direction_word[b+1];
         return x >> (32 - FRACTION_BITS);
      endfunction

      function void note_point(bit [31:0] point_count);
         expected_coordinates.push_back(coordinate_of(point_count));
         points_noted++;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_coordinate(logic [31:0] coordinate);
         bit [31:0] want;
         coordinates_checked++;
         if (expected_coordinates.size() == 0) begin
            report_mismatch($sformatf("coordinate %h with no point pending", coordinate));
         end else begin
            want = expected_coordinates.pop_front();
            if (coordinate !== want)
               report_mismatch($sformatf("coordinate %h, expected %h", coordinate, want));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   sbl_req_if req_if ();
   sbl_rsp_if rsp_if ();
   sbl_csr_if csr_if ();

   sobol_point_generator_unit #(
      .MAX_DEGREE    (MAX_DEGREE),
      .FRACTION_BITS (FRACTION_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   coordinate_scoreboard sb = new();

   // Idle rates in percent, changed by the main sequence between phases.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   // The main sequence asks for a long receiver hold-off by bumping this count;
   // the receiver process serves each request with its own cycle counter.
   int unsigned hold_offs_asked;
   int unsigned setups_applied;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // All monitoring happens at the rising edge; every input was settled before
   // it, at the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) sb.write_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) sb.note_point(req_if.point_count);
         if (rsp_if.valid === 1'b1 && rsp_if.ready) sb.check_coordinate(rsp_if.coordinate);
      end
   end

   // Result receiver.  It drops ready at random, and during a requested hold-off
   // it keeps ready low long enough for the chain to fill and back up into
   // the request side.
   initial begin
      int unsigned hold_off_left;
      int unsigned hold_offs_served;
      hold_off_left    = 0;
      hold_offs_served = 0;
      rsp_if.ready     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left == 0 && hold_offs_served < hold_offs_asked) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_offs_served++;
         end
         if (hold_off_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one point count, with random idle cycles before it.  It is entered
   // and left at a falling edge.  Valid is left high on exit, so that a word
   // offered right after keeps valid up without a second assignment in one step.
   task automatic send_point(input logic [31:0] point_count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid       <= 1'b0;
         req_if.point_count <= $urandom;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.point_count <= point_count;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly full-range counts, with a share of small counts and of the corner
   // counts where the Gray code wraps or sets its top bit.
   function automatic logic [31:0] random_point_count();
      case ($urandom_range(9))
         0: return $urandom_range(64);
         1: begin
            case ($urandom_range(3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h8000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_points(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_point(random_point_count());
   endtask

   // One configuration word per call.  Like send_point, valid is left high.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Registers are only written once the block has drained.  Every word
   // yields a coordinate, so an empty scoreboard means the chain is empty.
   task automatic program_dimension(input logic first_dimension, input logic [3:0] degree,
                                    input logic [6:0] poly, input logic [63:0] initial_values);
      req_if.valid <= 1'b0;
      while (sb.expected_coordinates.size() != 0) @(negedge clock);
      write_register(CSR_FIRST_DIMENSION,    {63'd0, first_dimension});
      write_register(CSR_DEGREE,             {60'd0, degree});
      write_register(CSR_POLY_COEFFICIENTS,  {57'd0, poly});
      write_register(CSR_INITIAL_DIRECTIONS, initial_values);
      csr_if.valid <= 1'b0;
      setups_applied++;
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.point_count = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      send_idle_pct      = 29;
      recv_idle_pct      = 62;
      hold_offs_asked    = 0;
      setups_applied     = 1;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words on the reset setup, which is the first dimension.  They
      // cover the first few points, a zero count that wraps to the last
      // Gray-code index, the all-ones count and the counts around the top bit.
      send_point(32'd1);
      send_point(32'd2);
      send_point(32'd3);
      send_point(32'd4);
      send_point(32'd5);
      send_point(32'd0);
      send_point(32'hFFFF_FFFF);
      send_point(32'hFFFF_FFFE);
      send_point(32'h8000_0000);
      send_point(32'h8000_0001);
      send_point(32'h7FFF_FFFF);
      send_point(32'hAAAA_AAAA);
      send_point(32'h5555_5555);
      send_point(32'h0000_0100);
      send_point(32'h0001_0000);
      send_point(32'h0100_0001);
      send_random_points(POINTS_PER_SETUP - 16);

      // Classic low dimensions: x+1, x^2+x+1 with m = 1,3 and x^3+x+1 with
      // m = 1,3,1.
      program_dimension(1'b0, 4'd1, 7'd0, 64'h0101_0101_0101_0101);
      send_random_points(POINTS_PER_SETUP);
      program_dimension(1'b0, 4'd2, 7'd1, 64'h0000_0000_0000_0301);
      send_random_points(POINTS_PER_SETUP);
      program_dimension(1'b0, 4'd3, 7'd1, 64'h0000_0000_0001_0301);
      send_random_points(POINTS_PER_SETUP);

      // Swap the idle rates and move to the edges of the register ranges.
      send_idle_pct = 62;
      recv_idle_pct = 29;
      // Largest degree with every coefficient set and start values wider
      // than their slot, so the shifted bytes lose their top bits.
      program_dimension(1'b0, 4'd8, 7'h7F, 64'hFFFF_FFFF_FFFF_FFFF);
      send_random_points(POINTS_PER_SETUP);
      // Degree zero behaves as degree one; all-zero start values.
      program_dimension(1'b0, 4'd0, 7'h00, 64'h0);
      send_random_points(POINTS_PER_SETUP);
      // A degree above the maximum saturates.  The writes to indexes past the
      // register list must leave this setup untouched.
      program_dimension(1'b0, 4'd15, 7'($urandom), {$urandom, $urandom});
      @(negedge clock);
      write_register(CSR_UNUSED_INDEX, {$urandom, $urandom});
      write_register(CSR_TOP_INDEX, {$urandom, $urandom});
      csr_if.valid <= 1'b0;
      send_random_points(POINTS_PER_SETUP);
      // First dimension ignores the other registers, whatever they hold.
      program_dimension(1'b1, 4'($urandom), 7'($urandom), {$urandom, $urandom});
      send_random_points(POINTS_PER_SETUP);

      // Full rate on both sides, with one long receiver hold-off at the start
      // so the chain fills and the request side stalls behind it.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int unsigned setup = 0; setup < 4; setup++) begin
         program_dimension($urandom_range(3) == 0, 4'($urandom), 7'($urandom),
                           {$urandom, $urandom});
         if (setup == 0) hold_offs_asked++;
         send_random_points(POINTS_PER_SETUP);
      end

      req_if.valid <= 1'b0;
      while (sb.expected_coordinates.size() != 0) @(posedge clock);
      // Extra cycles catch any coordinate the block emits beyond the last one.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d point counts over %0d register setups, from the first dimension",
               sb.points_noted, setups_applied);
      $display("to degree 8, with a long output stall; %0d coordinates seen, %0d mismatches.",
               sb.coordinates_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a block that hangs on either handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d coordinates still pending.",
               sb.expected_coordinates.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sobol_point_generator_unit.f @@
rtl/sbl_pkg.sv
rtl/sbl_req_if.sv
rtl/sbl_rsp_if.sv
rtl/sbl_csr_if.sv
rtl/sbl_cell.sv
rtl/sbl_dir_builder.sv
rtl/sobol_point_generator_unit.sv
dv/sobol_point_generator_unit_tb.sv
